// ===== rtl/mouse_button_click_tracker_macros.svh =====
// Assertion helpers for the click tracker.
// Both forms sample on the rising edge of clock and stay quiet while reset is high.
`ifndef MOUSE_BUTTON_CLICK_TRACKER_MACROS_SVH
`define MOUSE_BUTTON_CLICK_TRACKER_MACROS_SVH

`ifndef SYNTHESIS

`define MBCT_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("mbct assertion failed");

`define MBCT_ASSERT_NEXT(label, ante, cons) \
   `MBCT_ASSERT(label, (ante) |=> (cons))

`else

`define MBCT_ASSERT(label, prop)

`define MBCT_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ===== rtl/mbct_pkg.sv =====
`default_nettype none

package mbct_pkg;

   localparam int TIME_W    = 61;
   localparam int COORD_W   = 16;
   localparam int BTN_W     = 3;
   localparam int OPCODE_W  = 3;
   localparam int TALLY_W   = 8;

   localparam logic [TALLY_W-1:0]        TALLY_MAX = 8'hFF;
   localparam logic signed [COORD_W-1:0] COORD_MAX = 16'sh7FFF;
   localparam logic signed [COORD_W-1:0] COORD_MIN = 16'sh8000;

   // input opcodes
   localparam logic [OPCODE_W-1:0] OP_TICK    = 3'd0;
   localparam logic [OPCODE_W-1:0] OP_MOVE    = 3'd1;
   localparam logic [OPCODE_W-1:0] OP_PRESS   = 3'd2;
   localparam logic [OPCODE_W-1:0] OP_RELEASE = 3'd3;
   localparam logic [OPCODE_W-1:0] OP_SCROLL  = 3'd4;

   // register file
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_IDX_W-1:0] CSR_HALF_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HALF_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_TIME = 2'd2;

   localparam logic [7:0]  HALF_WIDTH_RESET  = 8'd2;
   localparam logic [7:0]  HALF_HEIGHT_RESET = 8'd2;
   localparam logic [15:0] WINDOW_TIME_RESET = 16'd500;

   // queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QLVL_W      = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [OPCODE_W-1:0]       opcode;
      logic [BTN_W-1:0]          button;
      logic signed [COORD_W-1:0] coord_x;
      logic signed [COORD_W-1:0] coord_y;
      logic [TIME_W-1:0]         tick_time;
   } req_type;

   typedef struct packed {
      logic                      was_pressed_flag;
      logic                      was_released_flag;
      logic                      held_flag;
      logic [TIME_W-1:0]         held_duration;
      logic [TALLY_W-1:0]        repeat_clicks;
      logic signed [COORD_W-1:0] pointer_x;
      logic signed [COORD_W-1:0] pointer_y;
      logic signed [COORD_W-1:0] scroll_sum_x;
      logic signed [COORD_W-1:0] scroll_sum_y;
   } rsp_type;

   typedef struct packed {
      logic [7:0]  half_width;
      logic [7:0]  half_height;
      logic [15:0] window_time;
   } cfg_type;

   typedef enum logic [2:0] {
      CMD_NONE,
      CMD_TICK,
      CMD_MOVE,
      CMD_PRESS,
      CMD_RELEASE,
      CMD_SCROLL
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type              kind;
      logic                      btn_ok;
      logic [BTN_W-1:0]          button;
      logic signed [COORD_W-1:0] coord_x;
      logic signed [COORD_W-1:0] coord_y;
      logic [TIME_W-1:0]         tick_time;
   } cmd_type;

   typedef struct packed {
      logic [QLVL_W-1:0] level;
      logic              full;
      logic              empty;
   } queue_status_type;

   typedef struct packed {
      logic fire;
   } back_status_type;

endpackage

`default_nettype wire

// ===== rtl/mbct_front.sv =====
`default_nettype none

module mbct_front #(
   parameter int NUM_BUTTONS = 5
) (
   input  wire logic                       req_valid,
   output logic                            req_stall,
   input  mbct_pkg::req_type               req_data,
   input  mbct_pkg::queue_status_type      q_status,
   output logic                            push,
   output mbct_pkg::cmd_type               push_cmd
);
   import mbct_pkg::*;

   logic btn_ok;

   assign btn_ok    = req_data.button < BTN_W'(NUM_BUTTONS);
   assign req_stall = q_status.full;
   assign push      = req_valid && !q_status.full;

   // classify: presses and releases of a button that does not exist do nothing
   always_comb begin
      push_cmd.btn_ok    = btn_ok;
      push_cmd.button    = req_data.button;
      push_cmd.coord_x   = req_data.coord_x;
      push_cmd.coord_y   = req_data.coord_y;
      push_cmd.tick_time = req_data.tick_time;
      case (req_data.opcode)
         OP_TICK:    push_cmd.kind = CMD_TICK;
         OP_MOVE:    push_cmd.kind = CMD_MOVE;
         OP_PRESS:   push_cmd.kind = btn_ok ? CMD_PRESS : CMD_NONE;
         OP_RELEASE: push_cmd.kind = btn_ok ? CMD_RELEASE : CMD_NONE;
         OP_SCROLL:  push_cmd.kind = CMD_SCROLL;
         default:    push_cmd.kind = CMD_NONE;
      endcase
   end

endmodule

`default_nettype wire

// ===== rtl/mbct_queue.sv =====
`default_nettype none

module mbct_queue (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   push,
   input  mbct_pkg::cmd_type           push_cmd,
   input  wire logic                   pop,
   output mbct_pkg::cmd_type           head_cmd,
   output mbct_pkg::queue_status_type  status
);
   import mbct_pkg::*;

   cmd_type             entries_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff;
   logic [QPTR_W-1:0]   rd_ptr_ff;
   logic [QLVL_W-1:0]   level_ff;
   logic [QLVL_W-1:0]   level_in;

   assign head_cmd     = entries_ff[rd_ptr_ff];
   assign status.level = level_ff;
   assign status.full  = level_ff == QLVL_W'(QUEUE_DEPTH);
   assign status.empty = level_ff == '0;

   always_comb begin
      level_in = level_ff;
      if (push && !pop) begin
         level_in = level_ff + QLVL_W'(1);
      end else if (pop && !push) begin
         level_in = level_ff - QLVL_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + QPTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + QPTR_W'(1);
         end
         level_ff <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/mbct_back.sv =====
`default_nettype none

module mbct_back #(
   parameter int NUM_BUTTONS = 5
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  mbct_pkg::cfg_type              cfg,
   input  mbct_pkg::cmd_type              cmd,
   input  mbct_pkg::queue_status_type     q_status,
   input  wire logic                      rsp_stall,
   output logic                           rsp_valid,
   output mbct_pkg::rsp_type              rsp_data,
   output mbct_pkg::back_status_type      status
);
   import mbct_pkg::*;

   localparam int EXT_W = COORD_W + 1;

   logic                      fire;
   logic [NUM_BUTTONS-1:0]    sel;

   logic [NUM_BUTTONS-1:0]    pressed_ff,  pressed_in;
   logic [NUM_BUTTONS-1:0]    released_ff, released_in;
   logic [NUM_BUTTONS-1:0]    held_ff,     held_in;
   logic [TIME_W-1:0]         stamp_ff [NUM_BUTTONS];
   logic [TIME_W-1:0]         stamp_sel;

   logic [TIME_W-1:0]         now_ff, now_in;
   logic [BTN_W-1:0]          last_idx_ff;
   logic signed [COORD_W-1:0] last_px_ff, last_py_ff;
   logic [TIME_W-1:0]         last_stamp_ff;
   logic [TALLY_W-1:0]        tally_ff, tally_in, tally_base;
   logic signed [COORD_W-1:0] cursor_x_ff, cursor_x_in;
   logic signed [COORD_W-1:0] cursor_y_ff, cursor_y_in;
   logic signed [COORD_W-1:0] scroll_x_ff, scroll_x_in;
   logic signed [COORD_W-1:0] scroll_y_ff, scroll_y_in;

   logic signed [EXT_W-1:0]   cur_x_ext, cur_y_ext, px_ext, py_ext, hw_ext, hh_ext;
   logic                      in_area;
   logic [TIME_W-1:0]         gap;
   logic                      repeat_click;
   logic                      is_press;

   logic                      rsp_valid_ff;
   rsp_type                   rsp_data_ff, rsp_data_in;

   function automatic logic signed [COORD_W-1:0] sat_add(
      input logic signed [COORD_W-1:0] a,
      input logic signed [COORD_W-1:0] b
   );
      logic signed [EXT_W-1:0] sum;
      sum = EXT_W'(a) + EXT_W'(b);
      if (sum[EXT_W-1] != sum[EXT_W-2]) begin
         return sum[EXT_W-1] ? COORD_MIN : COORD_MAX;
      end
      return sum[COORD_W-1:0];
   endfunction

   // execute the head of the queue once the output register has room
   assign fire        = !q_status.empty && (!rsp_valid_ff || !rsp_stall);
   assign status.fire = fire;
   assign is_press    = cmd.kind == CMD_PRESS;

   always_comb begin
      for (int i = 0; i < NUM_BUTTONS; i++) begin
         sel[i] = cmd.btn_ok && (cmd.button == BTN_W'(i));
      end
   end

   // multi-click test against the previous press
   assign cur_x_ext = EXT_W'(cursor_x_ff);
   assign cur_y_ext = EXT_W'(cursor_y_ff);
   assign px_ext    = EXT_W'(last_px_ff);
   assign py_ext    = EXT_W'(last_py_ff);
   assign hw_ext    = $signed(EXT_W'(cfg.half_width));
   assign hh_ext    = $signed(EXT_W'(cfg.half_height));
   assign in_area   = (cur_x_ext >= px_ext - hw_ext) && (cur_x_ext < px_ext + hw_ext) &&
                      (cur_y_ext >= py_ext - hh_ext) && (cur_y_ext < py_ext + hh_ext);
   assign gap       = now_ff - last_stamp_ff;
   assign repeat_click = (cmd.button == last_idx_ff) && in_area &&
                         (gap <= TIME_W'(cfg.window_time));

   assign tally_base = repeat_click ? tally_ff : '0;

   always_comb begin
      pressed_in  = pressed_ff;
      released_in = released_ff;
      held_in     = held_ff;
      now_in      = now_ff;
      tally_in    = tally_ff;
      cursor_x_in = cursor_x_ff;
      cursor_y_in = cursor_y_ff;
      scroll_x_in = scroll_x_ff;
      scroll_y_in = scroll_y_ff;
      case (cmd.kind)
         CMD_TICK: begin
            now_in      = cmd.tick_time;
            pressed_in  = '0;
            released_in = '0;
            scroll_x_in = '0;
            scroll_y_in = '0;
         end
         CMD_MOVE: begin
            cursor_x_in = cmd.coord_x;
            cursor_y_in = cmd.coord_y;
         end
         CMD_PRESS: begin
            pressed_in = pressed_ff | sel;
            held_in    = held_ff | sel;
            tally_in   = (tally_base == TALLY_MAX) ? TALLY_MAX : tally_base + TALLY_W'(1);
         end
         CMD_RELEASE: begin
            held_in     = held_ff & ~sel;
            released_in = released_ff | sel;
         end
         CMD_SCROLL: begin
            scroll_x_in = sat_add(scroll_x_ff, cmd.coord_x);
            scroll_y_in = sat_add(scroll_y_ff, cmd.coord_y);
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      stamp_sel = '0;
      for (int i = 0; i < NUM_BUTTONS; i++) begin
         stamp_sel = stamp_sel | (sel[i] ? stamp_ff[i] : '0);
      end
   end

   // report from the state as it stands after this item
   always_comb begin
      rsp_data_in.was_pressed_flag  = |(pressed_in & sel);
      rsp_data_in.was_released_flag = |(released_in & sel);
      rsp_data_in.held_flag         = |(held_in & sel);
      if (!(|(held_in & sel)) || is_press) begin
         rsp_data_in.held_duration = '0;
      end else begin
         rsp_data_in.held_duration = now_in - stamp_sel;
      end
      rsp_data_in.repeat_clicks = tally_in;
      rsp_data_in.pointer_x     = cursor_x_in;
      rsp_data_in.pointer_y     = cursor_y_in;
      rsp_data_in.scroll_sum_x  = scroll_x_in;
      rsp_data_in.scroll_sum_y  = scroll_y_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pressed_ff    <= '0;
         released_ff   <= '0;
         held_ff       <= '0;
         now_ff        <= '0;
         last_idx_ff   <= BTN_W'(NUM_BUTTONS);
         last_px_ff    <= '0;
         last_py_ff    <= '0;
         last_stamp_ff <= '0;
         tally_ff      <= '0;
         cursor_x_ff   <= '0;
         cursor_y_ff   <= '0;
         scroll_x_ff   <= '0;
         scroll_y_ff   <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (fire) begin
            pressed_ff  <= pressed_in;
            released_ff <= released_in;
            held_ff     <= held_in;
            now_ff      <= now_in;
            tally_ff    <= tally_in;
            cursor_x_ff <= cursor_x_in;
            cursor_y_ff <= cursor_y_in;
            scroll_x_ff <= scroll_x_in;
            scroll_y_ff <= scroll_y_in;
            if (is_press) begin
               last_idx_ff   <= cmd.button;
               last_px_ff    <= cursor_x_ff;
               last_py_ff    <= cursor_y_ff;
               last_stamp_ff <= now_ff;
            end
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_data_ff <= rsp_data_in;
      end
      for (int i = 0; i < NUM_BUTTONS; i++) begin
         if (fire && is_press && sel[i]) begin
            stamp_ff[i] <= now_ff;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

// ===== rtl/mouse_button_click_tracker.sv =====
// Pointer tracker with multi-click counting. Each transfer on the req channel carries one event
// (tick, move, press, release or scroll) and yields exactly one transfer on the rsp channel,
// in order, reporting the named button's pressed, released and held flags and hold time,
// the click count, the pointer position and the scroll sums after that event. The block takes
// one event per clock cycle in steady flow. An event enters the queue at its transfer edge;
// the back end applies it and loads the output register once the entry is at the head of the
// queue and the output register is free or draining, and the result is offered from there.
// So the queue entry and the output register lie between a taken event and its result. A
// two-entry queue sits between the classifying front end and the back end, so a stalled
// result holds the back end while the front end keeps taking events until the queue fills.
// The half width, half height and time window of the multi-click test are written over the
// csr port at byte addresses 0, 4 and 8; write them only while no event is in flight.
`default_nettype none

`include "mouse_button_click_tracker_macros.svh"

module mouse_button_click_tracker #(
   parameter int NUM_BUTTONS = 5
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   // event input
   input  wire logic                                   req_valid,
   output logic                                        req_stall,
   input  mbct_pkg::req_type                           req_data,
   // result output
   output logic                                        rsp_valid,
   input  wire logic                                   rsp_stall,
   output mbct_pkg::rsp_type                           rsp_data,
   // register port
   input  wire logic                                   csr_psel,
   input  wire logic                                   csr_penable,
   input  wire logic                                   csr_pwrite,
   input  wire logic [mbct_pkg::CSR_ADDR_W-1:0]        csr_paddr,
   input  wire logic [mbct_pkg::CSR_DATA_W-1:0]        csr_pwdata,
   output logic [mbct_pkg::CSR_DATA_W-1:0]             csr_prdata,
   output logic                                        csr_pready
);
   import mbct_pkg::*;

   cfg_type             cfg_ff;
   logic                csr_write;
   logic [CSR_IDX_W-1:0] csr_idx;

   logic                push;
   cmd_type             push_cmd;
   cmd_type             head_cmd;
   queue_status_type    q_status;
   back_status_type     back_status;

   // ---------------------------------------------------------------------------------------
   // Register port: no wait states, so a write lands at the access phase edge.
   // The low two address bits are ignored; an index past the last register is dropped.
   // ---------------------------------------------------------------------------------------
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_idx    = csr_paddr[CSR_ADDR_W-1:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.half_width  <= HALF_WIDTH_RESET;
         cfg_ff.half_height <= HALF_HEIGHT_RESET;
         cfg_ff.window_time <= WINDOW_TIME_RESET;
      end else if (csr_write) begin
         case (csr_idx)
            CSR_HALF_WIDTH:  cfg_ff.half_width  <= csr_pwdata[7:0];
            CSR_HALF_HEIGHT: cfg_ff.half_height <= csr_pwdata[7:0];
            CSR_WINDOW_TIME: cfg_ff.window_time <= csr_pwdata[15:0];
            default: begin
            end
         endcase
      end
   end

   // read back the register at the address; unmapped addresses read as zero
   always_comb begin
      case (csr_idx)
         CSR_HALF_WIDTH:  csr_prdata = CSR_DATA_W'(cfg_ff.half_width);
         CSR_HALF_HEIGHT: csr_prdata = CSR_DATA_W'(cfg_ff.half_height);
         CSR_WINDOW_TIME: csr_prdata = CSR_DATA_W'(cfg_ff.window_time);
         default:         csr_prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------------------------------
   // Front end: decode the opcode, check the button index and push into the queue.
   // Stall only when the queue is full.
   // ---------------------------------------------------------------------------------------
   mbct_front #(
      .NUM_BUTTONS (NUM_BUTTONS)
   ) u_front (
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .q_status  (q_status),
      .push      (push),
      .push_cmd  (push_cmd)
   );

   // ---------------------------------------------------------------------------------------
   // Queue: decouple the front end from a stalled result channel.
   // ---------------------------------------------------------------------------------------
   mbct_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (back_status.fire),
      .head_cmd (head_cmd),
      .status   (q_status)
   );

   // ---------------------------------------------------------------------------------------
   // Back end: apply the event to the tracker state and load the result register.
   // Advance whenever the queue holds an event and the result register is free or draining.
   // ---------------------------------------------------------------------------------------
   mbct_back #(
      .NUM_BUTTONS (NUM_BUTTONS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .cmd       (head_cmd),
      .q_status  (q_status),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .status    (back_status)
   );

   // ---------------------------------------------------------------------------------------
   // Checks
   // ---------------------------------------------------------------------------------------
   // a button that is not held reports no hold time
   `MBCT_ASSERT(a_idle_button_no_duration,
      (rsp_valid && !rsp_data.held_flag) |-> (rsp_data.held_duration == '0))
   // the queue never holds more than its depth
   `MBCT_ASSERT(a_queue_level_bound, q_status.level <= QLVL_W'(QUEUE_DEPTH))
   // every event the back end executes shows up as a result on the next cycle
   `MBCT_ASSERT_NEXT(a_fire_gives_result, back_status.fire, rsp_valid)

endmodule

`default_nettype wire
